/* src/qat_pkg.sv */
package qat_pkg;

  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_BSLASH = 8'd92;
  localparam logic [7:0] CH_QUOTE  = 8'd34;

  localparam logic [5:0] ARG_LIMIT_RESET = 6'd31;

  // Register index as decoded from paddr[2].
  localparam logic REG_ARG_LIMIT = 1'b0;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_STRAY_QUOTE = 2'd1;
  localparam logic [1:0] STATUS_AFTER_QUOTE = 2'd2;
  localparam logic [1:0] STATUS_NO_CLOSE    = 2'd3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] arg_byte;
    logic [5:0] arg_index;
    logic       arg_end;
    logic [1:0] status;
    logic [5:0] args_found;
    logic       last;
  } out_word_t;

  // Results raised by one accepted word: count, then up to two words in order.
  typedef struct packed {
    logic [1:0] count;
    out_word_t  first;
    out_word_t  second;
  } push_t;

endpackage

/* src/quoted_argument_tokenizer.sv */
// Result words are registered in the result queue and offered in order, behind any words already queued.
// Throughput: one input word per cycle while the queue has room; an end word that releases a held byte
// raises two results, delivered in order from a four-word result queue.
// Input is taken while the queue has room for two words.
// Reset (rst, synchronous): parse state and queue are cleared, arg_limit returns to 31.
module quoted_argument_tokenizer (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  qat_pkg::in_word_t  item,
  output logic               res_valid,
  input  logic               res_ready,
  output qat_pkg::out_word_t res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic           take;
  logic           space;
  logic [5:0]     arg_limit;
  qat_pkg::push_t push;

  assign pready     = 1'b1;
  assign item_ready = space;
  assign take       = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      arg_limit <= qat_pkg::ARG_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == qat_pkg::REG_ARG_LIMIT) begin
      arg_limit <= pwdata[5:0];
    end
  end

  assign prdata = (paddr[2] == qat_pkg::REG_ARG_LIMIT) ? {26'd0, arg_limit} : 32'd0;

  qat_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .word      (item),
    .arg_limit (arg_limit),
    .push      (push)
  );

  qat_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space     (space),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

/* src/qat_parser.sv */
module qat_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  qat_pkg::in_word_t word,
  input  logic [5:0]       arg_limit,
  output qat_pkg::push_t   push
);

  typedef enum logic [2:0] {
    MODE_SKIP,
    MODE_UNQ,
    MODE_QUO,
    MODE_AFTER,
    MODE_IGNORE
  } mode_t;

  mode_t      mode, mode_next;
  logic       esc, esc_next;
  logic [7:0] held_byte, held_byte_next;
  logic       held_valid, held_valid_next;
  logic [5:0] completed, completed_next;
  logic [1:0] fail_code, fail_code_next;

  always_comb begin
    logic [7:0]         b;
    logic               ws;
    logic               emit;
    logic               emit_end;
    logic               store;
    qat_pkg::out_word_t byte_word;
    qat_pkg::out_word_t stat_word;

    b    = word.data_byte;
    ws   = (b == qat_pkg::CH_SPACE) || (b == qat_pkg::CH_TAB);
    emit = 1'b0;
    emit_end = 1'b0;
    store = 1'b0;

    mode_next       = mode;
    esc_next        = esc;
    held_byte_next  = held_byte;
    held_valid_next = held_valid;
    completed_next  = completed;
    fail_code_next  = fail_code;

    if (word.cmd) begin
      if (mode == MODE_UNQ && held_valid) begin
        emit           = 1'b1;
        emit_end       = 1'b1;
        completed_next = completed + 6'd1;
      end else if (mode == MODE_QUO) begin
        fail_code_next = qat_pkg::STATUS_NO_CLOSE;
      end
    end else begin
      case (mode)
        MODE_SKIP: begin
          if (!ws) begin
            if (completed >= arg_limit) begin
              mode_next = MODE_IGNORE;
            end else begin
              esc_next        = 1'b0;
              held_valid_next = 1'b0;
              if (b == qat_pkg::CH_QUOTE) begin
                mode_next = MODE_QUO;
              end else begin
                mode_next = MODE_UNQ;
                esc_next  = (b == qat_pkg::CH_BSLASH);
                // The first byte of an argument is held; nothing is emitted yet.
                held_byte_next  = b;
                held_valid_next = 1'b1;
              end
            end
          end
        end
        MODE_UNQ: begin
          if (esc) begin
            esc_next = 1'b0;
            store    = 1'b1;
          end else if (ws) begin
            emit            = held_valid;
            emit_end        = 1'b1;
            held_valid_next = 1'b0;
            if (held_valid) completed_next = completed + 6'd1;
            mode_next = MODE_SKIP;
          end else if (b == qat_pkg::CH_QUOTE) begin
            fail_code_next  = qat_pkg::STATUS_STRAY_QUOTE;
            mode_next       = MODE_IGNORE;
            held_valid_next = 1'b0;
            esc_next        = 1'b0;
          end else begin
            esc_next = (b == qat_pkg::CH_BSLASH);
            store    = 1'b1;
          end
        end
        MODE_QUO: begin
          if (esc) begin
            esc_next = 1'b0;
            store    = 1'b1;
          end else if (b == qat_pkg::CH_QUOTE) begin
            emit            = held_valid;
            emit_end        = 1'b1;
            held_valid_next = 1'b0;
            if (held_valid) completed_next = completed + 6'd1;
            mode_next = MODE_AFTER;
          end else begin
            esc_next = (b == qat_pkg::CH_BSLASH);
            store    = 1'b1;
          end
        end
        MODE_AFTER: begin
          if (ws) begin
            mode_next = MODE_SKIP;
          end else begin
            fail_code_next  = qat_pkg::STATUS_AFTER_QUOTE;
            mode_next       = MODE_IGNORE;
            held_valid_next = 1'b0;
            esc_next        = 1'b0;
          end
        end
        default: begin
          mode_next = MODE_IGNORE;
        end
      endcase
      if (store) begin
        // The previous byte is released once its successor is known.
        emit            = held_valid;
        emit_end        = 1'b0;
        held_byte_next  = b;
        held_valid_next = 1'b1;
      end
    end

    byte_word            = '0;
    byte_word.arg_byte   = held_byte;
    byte_word.arg_index  = completed + 6'd1;
    byte_word.arg_end    = emit_end;
    byte_word.last       = !word.cmd;

    stat_word            = '0;
    stat_word.is_status  = 1'b1;
    stat_word.status     = fail_code_next;
    stat_word.args_found = completed_next;
    stat_word.last       = 1'b1;

    push = '0;
    if (take) begin
      if (word.cmd) begin
        if (emit) begin
          push.count  = 2'd2;
          push.first  = byte_word;
          push.second = stat_word;
        end else begin
          push.count = 2'd1;
          push.first = stat_word;
        end
      end else if (emit) begin
        push.count = 2'd1;
        push.first = byte_word;
      end
    end

    // The end word returns the message state to its reset values.
    if (word.cmd) begin
      mode_next       = MODE_SKIP;
      esc_next        = 1'b0;
      held_valid_next = 1'b0;
      completed_next  = '0;
      fail_code_next  = qat_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_SKIP;
      esc        <= 1'b0;
      held_valid <= 1'b0;
      completed  <= '0;
      fail_code  <= qat_pkg::STATUS_OK;
    end else if (take) begin
      mode       <= mode_next;
      esc        <= esc_next;
      held_valid <= held_valid_next;
      completed  <= completed_next;
      fail_code  <= fail_code_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) held_byte <= held_byte_next;
  end

endmodule

/* src/qat_queue.sv */
module qat_queue (
  input  logic               clk,
  input  logic               rst,
  input  qat_pkg::push_t     push,
  output logic               space,
  output logic               res_valid,
  input  logic               res_ready,
  output qat_pkg::out_word_t res
);

  qat_pkg::out_word_t mem [qat_pkg::QUEUE_DEPTH];

  logic [qat_pkg::QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [qat_pkg::QUEUE_AW:0]   count, count_next;
  logic                         pop;

  assign pop       = res_valid && res_ready;
  assign res_valid = (count != '0);
  assign res       = mem[rd_ptr];
  // Room for the two words an end word may raise, whatever the reader does.
  assign space     = (count <= (qat_pkg::QUEUE_AW + 1)'(qat_pkg::QUEUE_DEPTH - 2));

  assign count_next = count + (qat_pkg::QUEUE_AW + 1)'(push.count)
                    - (qat_pkg::QUEUE_AW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + qat_pkg::QUEUE_AW'(push.count);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.first;
    if (push.count == 2'd2) mem[wr_ptr + 1'b1] <= push.second;
  end

endmodule
